// ----- hdl/vifd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vifd_pkg: shared types and constants for the instruction fetch/decode block
// item and result payloads, segment table port structs, status codes
// ----------------------------------------------------------------------------
package vifd_pkg;

  localparam logic KIND_SEG_WRITE = 1'b0;
  localparam logic KIND_DECODE    = 1'b1;

  localparam logic [31:0] STOP_PTR   = 32'hFFFF_FFFF;
  localparam logic [23:0] VALUE_MASK = 24'hFF_FFFF;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_STOP   = 2'd1,
    ST_BADSEG = 2'd2,
    ST_BOUNDS = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OPT_NONE = 2'd0,
    OPT_REG  = 2'd1,
    OPT_IMM  = 2'd2,
    OPT_MEM  = 2'd3
  } opnd_type_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] instr_ptr;
    logic [55:0] instr_bytes;
    logic [2:0]  seg_index;
    logic [13:0] seg_base;
    logic [14:0] seg_size;
    logic        seg_valid;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [4:0]  opcode;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic [2:0]  instr_length;
    logic [31:0] next_ptr;
    logic [14:0] phys_addr;
  } out_item_t;

  // segment table write port
  typedef struct packed {
    logic        en;
    logic [2:0]  index;
    logic [13:0] base;
    logic [14:0] size;
    logic        valid;
  } seg_wr_t;

  // segment table lookup answer
  typedef struct packed {
    logic        hit;
    logic [13:0] base;
    logic [14:0] size;
  } seg_look_t;

  // checked and first-byte decoded item, between stages two and three
  typedef struct packed {
    status_t     status;
    logic        is_decode;
    logic [4:0]  opcode;
    opnd_type_t  type_a;
    opnd_type_t  type_b;
    logic [47:0] opnd_bytes;
    logic [31:0] ptr;
    logic [13:0] base;
    logic [15:0] offset;
  } dec_t;

endpackage

// ----- hdl/vm_instruction_fetch_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vm_instruction_fetch_decode: segmented vm instruction fetch/decode front end
// segment table writes and instruction decodes through a three-stage pipeline
// ----------------------------------------------------------------------------
//
//  channel | signals                             | payload
//  --------+-------------------------------------+---------------------------
//  item    | item_valid / item_ready / item      | in_item_t  (write or decode)
//  result  | result_valid / result_ready / result| out_item_t (one per item)
//
//  one item per clock cycle sustained while result_ready is held high; a result
//  passes the input register, the check/decode register and the result register
//  in turn, and can transfer out once it is in the result register
//  the per-stage ready chain lets a full pipe still take a new item in the
//  cycle that its result register is emptied
//  reset clears the stage valid bits and the segment valid flags
//  table writes land at the input transfer, so later decodes see them
//
module vm_instruction_fetch_decode #(
  parameter int NUM_SEGMENTS = 8,
  parameter int MEM_BYTES    = 16384
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  vifd_pkg::in_item_t  item,
  output logic                result_valid,
  input  logic                result_ready,
  output vifd_pkg::out_item_t result
);
  import vifd_pkg::*;

  // stage registers
  logic      s1_valid;
  in_item_t  s1_item;
  logic      s2_valid;
  dec_t      s2_dec;
  logic      s3_valid;
  out_item_t s3_res;

  // stage readies: a stage can load when empty or when it is moving on
  logic s1_ready;
  logic s2_ready;
  logic s3_ready;

  seg_wr_t   seg_wr;
  seg_look_t seg_look;
  dec_t      dec_next;
  out_item_t res_next;

  logic [7:0]  byte0;
  logic [15:0] ptr_seg;
  logic [15:0] ptr_off;

  assign s3_ready   = !s3_valid || result_ready;
  assign s2_ready   = !s2_valid || s3_ready;
  assign s1_ready   = !s1_valid || s2_ready;
  assign item_ready = s1_ready;

  // ---------------- stage 1: input register and table write ----------------
  always_comb begin
    seg_wr       = '0;
    seg_wr.en    = item_valid && item_ready && (item.kind == KIND_SEG_WRITE);
    seg_wr.index = item.seg_index;
    seg_wr.base  = item.seg_base;
    seg_wr.size  = item.seg_size;
    seg_wr.valid = item.seg_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && item_valid) begin
      s1_item <= item;
    end
  end

  // ---------------- stage 2: segment check and first-byte decode ----------
  assign ptr_seg = s1_item.instr_ptr[31:16];
  assign ptr_off = s1_item.instr_ptr[15:0];
  assign byte0   = s1_item.instr_bytes[55:48];

  vifd_seg_table #(
    .NUM_SEGMENTS (NUM_SEGMENTS),
    .MEM_BYTES    (MEM_BYTES)
  ) u_seg_table (
    .clk    (clk),
    .rst    (rst),
    .wr     (seg_wr),
    .rd_seg (ptr_seg),
    .look   (seg_look)
  );

  always_comb begin
    dec_next            = '0;
    dec_next.is_decode  = (s1_item.kind == KIND_DECODE);
    dec_next.opnd_bytes = s1_item.instr_bytes[47:0];
    dec_next.ptr        = s1_item.instr_ptr;
    dec_next.base       = seg_look.base;
    dec_next.offset     = ptr_off;

    // stop pointer wins over the segment checks
    if (!dec_next.is_decode) begin
      dec_next.status = ST_OK;
    end else if (s1_item.instr_ptr == STOP_PTR) begin
      dec_next.status = ST_STOP;
    end else if (!seg_look.hit) begin
      dec_next.status = ST_BADSEG;
    end else if (ptr_off >= 16'(seg_look.size)) begin
      dec_next.status = ST_BOUNDS;
    end else begin
      dec_next.status = ST_OK;
    end

    // short form when bits 5:4 are clear: one operand type in 7:6
    if (byte0[5:4] == 2'b00) begin
      dec_next.opcode = byte0[4:0];
      dec_next.type_a = opnd_type_t'(byte0[7:6]);
      dec_next.type_b = OPT_NONE;
    end else begin
      dec_next.opcode = {1'b1, byte0[3:0]};
      dec_next.type_a = opnd_type_t'(byte0[5:4]);
      dec_next.type_b = opnd_type_t'(byte0[7:6]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_dec <= dec_next;
    end
  end

  // ---------------- stage 3: operands and result register ------------------
  vifd_opnd_extract u_opnd_extract (
    .dec (s2_dec),
    .res (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid) begin
      s3_res <= res_next;
    end
  end

  assign result_valid = s3_valid;
  assign result       = s3_res;

endmodule

// ----- hdl/vifd_seg_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vifd_seg_table: segment descriptor table
// one write port with size saturation, one lookup with range and valid check
// ----------------------------------------------------------------------------
module vifd_seg_table #(
  parameter int NUM_SEGMENTS = 8,
  parameter int MEM_BYTES    = 16384
) (
  input  logic                clk,
  input  logic                rst,
  input  vifd_pkg::seg_wr_t   wr,
  input  logic [15:0]         rd_seg,
  output vifd_pkg::seg_look_t look
);
  import vifd_pkg::*;

  localparam int IDX_W = $clog2(NUM_SEGMENTS);

  logic [13:0]             base_mem [NUM_SEGMENTS];
  logic [14:0]             size_mem [NUM_SEGMENTS];
  logic [NUM_SEGMENTS-1:0] valid_flags;

  logic             wr_in_range;
  logic [IDX_W-1:0] wr_idx;
  logic [14:0]      wr_size_sat;
  logic             rd_in_range;
  logic [IDX_W-1:0] rd_idx;

  assign wr_in_range = 32'(wr.index) < 32'(NUM_SEGMENTS);
  assign wr_idx      = IDX_W'(wr.index);
  assign wr_size_sat = (32'(wr.size) > 32'(MEM_BYTES)) ? 15'(MEM_BYTES) : wr.size;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_flags <= '0;
    end else if (wr.en && wr_in_range) begin
      valid_flags[wr_idx] <= wr.valid;
    end
  end

  // base and size are only looked at behind a set valid flag
  always_ff @(posedge clk) begin
    if (wr.en && wr_in_range) begin
      base_mem[wr_idx] <= wr.base;
      size_mem[wr_idx] <= wr_size_sat;
    end
  end

  assign rd_in_range = 32'(rd_seg) < 32'(NUM_SEGMENTS);
  assign rd_idx      = IDX_W'(rd_seg);

  always_comb begin
    look = '0;
    if (rd_in_range) begin
      look.hit  = valid_flags[rd_idx];
      look.base = base_mem[rd_idx];
      look.size = size_mem[rd_idx];
    end
  end

endmodule

// ----- hdl/vifd_opnd_extract.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vifd_opnd_extract: operand extraction and result formatting
// pulls both operands from the byte window, forms length, next and phys address
// ----------------------------------------------------------------------------
module vifd_opnd_extract (
  input  vifd_pkg::dec_t    dec,
  output vifd_pkg::out_item_t res
);
  import vifd_pkg::*;

  function automatic logic [31:0] take_opnd(input logic [47:0] win,
                                            input opnd_type_t  kind_t,
                                            input logic [1:0]  start);
    logic [47:0] sh;
    logic [23:0] w;
    logic [23:0] v;
    sh = win << {start, 3'b000};
    w  = sh[47:24];
    case (kind_t)
      OPT_REG:  v = {16'h0000, w[23:16]};
      OPT_IMM:  v = {{8{w[23]}}, w[23:8]};
      OPT_MEM:  v = w;
      default:  v = '0;
    endcase
    if (kind_t == OPT_NONE) begin
      take_opnd = '0;
    end else begin
      take_opnd = {6'b000000, kind_t, v & VALUE_MASK};
    end
  endfunction

  logic [2:0] len;

  assign len = 3'd1 + 3'(dec.type_a) + 3'(dec.type_b);

  always_comb begin
    res        = '0;
    res.status = dec.status;
    if (dec.is_decode && dec.status == ST_OK) begin
      res.opcode       = dec.opcode;
      // first operand starts right after the first byte, second after the first
      res.operand_a    = take_opnd(dec.opnd_bytes, dec.type_a, 2'b00);
      res.operand_b    = take_opnd(dec.opnd_bytes, dec.type_b, dec.type_a);
      res.instr_length = len;
      res.next_ptr     = dec.ptr + 32'(len);
      res.phys_addr    = 15'(dec.base) + dec.offset[14:0];
    end
  end

endmodule

// ----- hdl/vifd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vifd_checker: port-level checks on the fetch/decode block
// result handshake, reset behaviour and result field consistency
// ----------------------------------------------------------------------------
module vifd_checker (
  input logic                clk,
  input logic                rst,
  input logic                result_valid,
  input logic                result_ready,
  input vifd_pkg::out_item_t result
);
  import vifd_pkg::*;

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed or dropped while stalled");

  // pipe is empty straight after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  // any error or stop result carries nothing but its status
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != ST_OK |->
      result.opcode == '0 && result.operand_a == '0 && result.operand_b == '0 &&
      result.instr_length == '0 && result.next_ptr == '0 && result.phys_addr == '0)
    else $error("fault result with non-zero fields");

  // a decoded instruction's length agrees with its operand types
  a_length_types: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_OK && result.instr_length != '0 |->
      result.instr_length ==
        3'(3'd1 + 3'(result.operand_a[25:24]) + 3'(result.operand_b[25:24])))
    else $error("instruction length does not match operand types");

endmodule

bind vm_instruction_fetch_decode vifd_checker u_vifd_checker (.*);
